// File: rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared constants and types for the stable card sorter.
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam int MAX_CARDS = 64;
   localparam int ADDR_W    = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
   localparam int CNT_W     = $clog2(MAX_CARDS + 1);
   localparam int BYTE_W    = 8;
   localparam int CARD_W    = 2 * BYTE_W;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  count_type;

   // one queued card word
   typedef struct packed {
      byte_type card_suit;
      byte_type card_rank;
      logic     last_card;
   } item_type;

   // stored card layout: suit in the upper byte, rank in the lower byte
   typedef struct packed {
      byte_type suit;
      byte_type rank;
   } card_type;

endpackage

// File: rtl/scs_if.sv
// ----------------------------------------------------------------------------
// scs_if
// Valid/ready channels for incoming cards and sorted results.
// ----------------------------------------------------------------------------
interface scs_req_if;
   import scs_pkg::*;

   logic     valid;
   logic     ready;
   byte_type card_suit;
   byte_type card_rank;
   logic     last_card;

   modport source (output valid, output card_suit, output card_rank, output last_card,
                   input ready);
   modport sink   (input valid, input card_suit, input card_rank, input last_card,
                   output ready);
endinterface

interface scs_rsp_if;
   import scs_pkg::*;

   logic     valid;
   logic     ready;
   byte_type sorted_suit;
   byte_type sorted_rank;
   logic     last_out;

   modport source (output valid, output sorted_suit, output sorted_rank, output last_out,
                   input ready);
   modport sink   (input valid, input sorted_suit, input sorted_rank, input last_out,
                   output ready);
endinterface

// File: rtl/stable_card_sort_top.sv
// ----------------------------------------------------------------------------
// stable_card_sort_top
// Stable ascending sort of card words by rank; emits the set on the last card.
// ----------------------------------------------------------------------------
//  port       | dir | carries
//  -----------+-----+------------------------------------------
//  req_chan   | in  | card_suit, card_rank, last_card
//  rsp_chan   | out | sorted_suit, sorted_rank, last_out
//
//  A card goes straight into an empty store; otherwise each stored card of
//  greater rank is shifted up before it is placed: the store RAM has one write
//  port and a registered read, so cards move up one slot per cycle.
//  Read-out uses the same read port: each card is read, then loaded out.
//  A two-word queue takes cards while the engine works or the output stalls.
//  Synchronous active-high reset empties the store; no clearing pass.
// ----------------------------------------------------------------------------
module stable_card_sort_top (
   input  logic      clock,
   input  logic      reset,
   scs_req_if.sink   req_chan,
   scs_rsp_if.source rsp_chan
);
   import scs_pkg::*;

   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   scs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   scs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: rtl/scs_ram.sv
// ----------------------------------------------------------------------------
// scs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/scs_front.sv
// ----------------------------------------------------------------------------
// scs_front
// Input side: accepts card words into a two-entry queue for the sort engine.
// ----------------------------------------------------------------------------
module scs_front (
   input  logic              clock,
   input  logic              reset,
   scs_req_if.sink           req_chan,
   output logic              q_valid,
   output scs_pkg::item_type q_item,
   input  logic              q_pop
);
   import scs_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       push;
   logic       pop;

   assign req_chan.ready = (fill_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = q_pop && (fill_ff != 2'd0);
   assign q_valid        = (fill_ff != 2'd0);
   assign q_item         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{card_suit: req_chan.card_suit,
                                  card_rank: req_chan.card_rank,
                                  last_card: req_chan.last_card};
      end
   end

endmodule

// File: rtl/scs_back.sv
// ----------------------------------------------------------------------------
// scs_back
// Sort engine: insertion into a sorted card RAM, then ordered read-out.
// ----------------------------------------------------------------------------
module scs_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  scs_pkg::item_type q_item,
   output logic              q_pop,
   scs_rsp_if.source         rsp_chan
);
   import scs_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_PLACE = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   localparam count_type FULL_COUNT = count_type'(MAX_CARDS);

   logic [1:0] state_ff;
   logic [1:0] state_in;
   count_type  count_ff;
   count_type  count_in;
   addr_type   pos_ff;
   addr_type   pos_in;
   addr_type   idx_ff;
   addr_type   idx_in;
   logic       primed_ff;
   logic       primed_in;
   item_type   card_ff;
   item_type   card_in;

   logic       out_valid_ff;
   logic       out_valid_in;
   byte_type   out_suit_ff;
   byte_type   out_suit_in;
   byte_type   out_rank_ff;
   byte_type   out_rank_in;
   logic       out_last_ff;
   logic       out_last_in;

   logic       wr_en;
   addr_type   wr_addr;
   card_type   wr_data;
   addr_type   rd_addr;
   card_type   rd_data;
   logic       load_out;
   logic       emit_last;

   scs_ram #(
      .WIDTH (CARD_W),
      .DEPTH (MAX_CARDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      primed_in    = primed_ff;
      card_in      = card_ff;
      out_valid_in = out_valid_ff;
      out_suit_in  = out_suit_ff;
      out_rank_in  = out_rank_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = '{suit: card_ff.card_suit, rank: card_ff.card_rank};
      rd_addr      = pos_ff - addr_type'(1);
      load_out     = 1'b0;
      emit_last    = (count_type'(idx_ff) == count_ff - count_type'(1));

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               card_in = q_item;
               if (count_ff == FULL_COUNT) begin
                  // drop the card, still honor its last flag
                  if (q_item.last_card) begin
                     state_in  = ST_EMIT;
                     idx_in    = '0;
                     primed_in = 1'b0;
                  end
               end else if (count_ff == '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = '{suit: q_item.card_suit, rank: q_item.card_rank};
                  count_in = count_type'(1);
                  if (q_item.last_card) begin
                     state_in  = ST_EMIT;
                     idx_in    = '0;
                     primed_in = 1'b0;
                  end
               end else begin
                  pos_in   = count_ff[ADDR_W-1:0];
                  rd_addr  = count_ff[ADDR_W-1:0] - addr_type'(1);
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (rd_data.rank > card_ff.card_rank) begin
               // shift the larger card up one slot
               wr_en   = 1'b1;
               wr_data = rd_data;
               pos_in  = pos_ff - addr_type'(1);
               if (pos_ff == addr_type'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_addr = pos_ff - addr_type'(2);
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + count_type'(1);
               if (card_ff.last_card) begin
                  state_in  = ST_EMIT;
                  idx_in    = '0;
                  primed_in = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + count_type'(1);
            if (card_ff.last_card) begin
               state_in  = ST_EMIT;
               idx_in    = '0;
               primed_in = 1'b0;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_EMIT: begin
            rd_addr   = idx_ff;
            primed_in = 1'b1;
            if (primed_ff && (!out_valid_ff || rsp_chan.ready)) begin
               load_out  = 1'b1;
               primed_in = 1'b0;
               idx_in    = idx_ff + addr_type'(1);
               if (emit_last) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_out) begin
         out_valid_in = 1'b1;
         out_suit_in  = rd_data.suit;
         out_rank_in  = rd_data.rank;
         out_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         primed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         primed_ff    <= primed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      card_ff     <= card_in;
      out_suit_ff <= out_suit_in;
      out_rank_ff <= out_rank_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.sorted_suit = out_suit_ff;
   assign rsp_chan.sorted_rank = out_rank_ff;
   assign rsp_chan.last_out    = out_last_ff;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stable_card_sort_top. Card words go in over the
// request channel and an internal stable insertion sort predicts each sorted
// run. Every returned word is compared with the oldest predicted one. A
// directed table covers single-card sets, extremes, ordered sets and equal
// ranks. Random sets follow, including a store filled exactly and one that
// overflows, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import scs_pkg::*;

   localparam int ITEM_TARGET  = 360;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 40;
   localparam int DIRECTED_N   = 22;

   typedef struct packed {
      byte_type suit;
      byte_type rank;
      logic     last;
      logic     typed;      // expected word written in the row
      byte_type exp_suit;
      byte_type exp_rank;
   } row_type;

   typedef struct packed {
      byte_type suit;
      byte_type rank;
      logic     last;
   } sorted_word_type;

   localparam row_type DIRECTED_ROWS [DIRECTED_N] = '{
      // single-card sets: the word comes straight back, flagged last
      '{8'hA5, 8'h3C, 1'b1, 1'b1, 8'hA5, 8'h3C},
      '{8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'hFF},
      '{8'h80, 8'h01, 1'b1, 1'b1, 8'h80, 8'h01},
      // already ascending
      '{8'h11, 8'h10, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h12, 8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h13, 8'h30, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h14, 8'h40, 1'b1, 1'b0, 8'h00, 8'h00},
      // descending, down to the bottom rank
      '{8'h21, 8'hF0, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h22, 8'h80, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h23, 8'h7F, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h24, 8'h01, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h25, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00},
      // equal ranks must keep arrival order
      '{8'h31, 8'h55, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h32, 8'h55, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h33, 8'h54, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h34, 8'h55, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h35, 8'h56, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h36, 8'h55, 1'b1, 1'b0, 8'h00, 8'h00},
      // mixed extremes
      '{8'h7F, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hFE, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h01, 8'h80, 1'b1, 1'b0, 8'h00, 8'h00}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   scs_req_if req_bus ();
   scs_rsp_if rsp_bus ();

   stable_card_sort_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   card_type        held_cards [MAX_CARDS];
   int              held_count  = 0;
   sorted_word_type sorted_due [$];
   int              error_count = 0;
   int              cycle_count = 0;
   bit              calm        = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stable insertion into the held set; on the last card, queue the run.
   function automatic void sort_card(input byte_type suit, input byte_type rank,
                                     input logic last, input bit emit);
      int              pos;
      int              k;
      sorted_word_type word;
      if (held_count < MAX_CARDS) begin
         pos = held_count;
         while (pos > 0 && held_cards[pos-1].rank > rank) begin
            held_cards[pos] = held_cards[pos-1];
            pos--;
         end
         held_cards[pos].suit = suit;
         held_cards[pos].rank = rank;
         held_count++;
      end
      if (last) begin
         if (emit) begin
            for (k = 0; k < held_count; k++) begin
               word.suit = held_cards[k].suit;
               word.rank = held_cards[k].rank;
               word.last = (k == held_count - 1);
               sorted_due.push_back(word);
            end
         end
         held_count = 0;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // Offer one word, hold it until taken, then predict.
   task automatic offer_card(input row_type row, input int gap);
      sorted_word_type word;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.card_suit <= row.suit;
      req_bus.card_rank <= row.rank;
      req_bus.last_card <= row.last;
      do @(posedge clock); while (!req_bus.ready);
      if (row.typed) begin
         sort_card(row.suit, row.rank, row.last, 1'b0);
         word.suit = row.exp_suit;
         word.rank = row.exp_rank;
         word.last = 1'b1;
         sorted_due.push_back(word);
      end else begin
         sort_card(row.suit, row.rank, row.last, 1'b1);
      end
   endtask

   initial begin : card_source
      int       sent;
      int       set_index;
      int       set_len;
      int       rank_mode;
      int       k;
      byte_type base;
      row_type  row;

      req_bus.valid     <= 1'b0;
      req_bus.card_suit <= '0;
      req_bus.card_rank <= '0;
      req_bus.last_card <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      sent = 0;
      for (k = 0; k < DIRECTED_N; k++) begin
         offer_card(DIRECTED_ROWS[k], pick_gap());
         sent++;
      end

      set_index = 0;
      while (sent < ITEM_TARGET) begin
         set_index++;
         if (set_index == 4)
            set_len = MAX_CARDS;
         else if (set_index == 12)
            set_len = MAX_CARDS + $urandom_range(1, 3);  // words past MAX_CARDS get dropped
         else if ($urandom_range(0, 9) == 0)
            set_len = 1;
         else
            set_len = $urandom_range(2, 12);
         calm      = ($urandom_range(0, 4) == 0);
         rank_mode = $urandom_range(0, 4);
         base      = byte_type'($urandom);
         for (k = 0; k < set_len; k++) begin
            row.suit = byte_type'($urandom);
            case (rank_mode)
               0: row.rank = byte_type'($urandom);
               1: row.rank = base + byte_type'($urandom_range(0, 3));
               2: row.rank = base + byte_type'(k);
               3: row.rank = base - byte_type'(k);
               default: row.rank = base;
            endcase
            row.last     = (k == set_len - 1);
            row.typed    = 1'b0;
            row.exp_suit = '0;
            row.exp_rank = '0;
            offer_card(row, pick_gap());
            sent++;
         end
      end

      req_bus.valid <= 1'b0;
      while (sorted_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin : result_sink
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(40, 100)) @(posedge clock);
         else
            repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : sorted_check
      sorted_word_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (sorted_due.size() == 0) begin
            $error("unexpected word: suit %0h rank %0h last %0b",
                   rsp_bus.sorted_suit, rsp_bus.sorted_rank, rsp_bus.last_out);
            error_count++;
         end else begin
            due = sorted_due.pop_front();
            if (rsp_bus.sorted_suit !== due.suit) begin
               $error("sorted_suit: expected %0h, got %0h", due.suit, rsp_bus.sorted_suit);
               error_count++;
            end
            if (rsp_bus.sorted_rank !== due.rank) begin
               $error("sorted_rank: expected %0h, got %0h", due.rank, rsp_bus.sorted_rank);
               error_count++;
            end
            if (rsp_bus.last_out !== due.last) begin
               $error("last_out: expected %0b, got %0b", due.last, rsp_bus.last_out);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
